// ----- hw/rtl/mtg_pkg.sv -----
// shared constants, types and helper functions of the mersenne twister generator
`default_nettype none
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS);
	localparam int WORD_W       = 32;
	localparam int FRAC_W       = 24;
	localparam int CNT_W        = 7;
	localparam int MAX_WORDS    = 64;

	localparam logic [WORD_W-1:0] TWIST_XOR_MASK = 32'h9908b0df;
	localparam logic [WORD_W-1:0] TOP_BIT_MASK   = 32'h80000000;
	localparam logic [WORD_W-1:0] LOW_BITS_MASK  = 32'h7fffffff;
	localparam logic [WORD_W-1:0] SEED_MULT      = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_B       = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C       = 32'hefc60000;
	localparam logic [WORD_W-1:0] SEED_RESET     = 32'd5489;

	// control handed from the sequencer to the row of cells
	typedef struct packed {
		logic             shift;
		logic             seed_mode;
		logic [IDX_W-1:0] seed_idx;
	} chain_ctrl_t;

	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt,
		input logic [WORD_W-1:0] far
	);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		y = (cur & TOP_BIT_MASK) | (nxt & LOW_BITS_MASK);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_XOR_MASK;
		end
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mtg_cell.sv -----
// one state word of the twister ring, loaded from its neighbor on shift
`default_nettype none
module mtg_cell
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire logic [WORD_W-1:0] d,
	output logic      [WORD_W-1:0] q
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mtg_chain.sv -----
// row of state cells with the seeding and twist feedback into the tail
`default_nettype none
module mtg_chain
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire chain_ctrl_t       ctrl,
	input  wire logic [WORD_W-1:0] seed,
	output logic      [WORD_W-1:0] new_word
);

	logic [WORD_W-1:0] cell_q [STATE_WORDS];
	logic [WORD_W-1:0] tail;
	logic [WORD_W-1:0] seed_mix;
	logic [WORD_W-1:0] seed_prod;
	logic [WORD_W-1:0] seed_next;
	logic [WORD_W-1:0] twist_next;

	// head of the ring is the oldest word, the tail takes the new one
	for (genvar j = 0; j < STATE_WORDS; j++) begin : g_cell
		logic [WORD_W-1:0] d;
		if (j == STATE_WORDS - 1) begin : g_tail
			assign d = new_word;
		end else begin : g_body
			assign d = cell_q[j+1];
		end
		mtg_cell u_cell (
			.clk   (clk),
			.shift (ctrl.shift),
			.d     (d),
			.q     (cell_q[j])
		);
	end

	assign tail       = cell_q[STATE_WORDS-1];
	assign seed_mix   = tail ^ (tail >> 30);
	assign seed_prod  = seed_mix * SEED_MULT;
	assign seed_next  = (ctrl.seed_idx == '0) ? seed
	                  : seed_prod + WORD_W'(ctrl.seed_idx);
	assign twist_next = twist_word(cell_q[0], cell_q[1], cell_q[TWIST_OFFSET]);
	assign new_word   = ctrl.seed_mode ? seed_next : twist_next;

endmodule
`default_nettype wire

// ----- hw/rtl/mersenne_twister_generator.sv -----
// top level of the mt19937 random word generator
// A draw beat asks for how_many words (zero gives none, above 64 counts as 64); the block
// returns that many beats, each with the tempered 32-bit word, its low 24 bits as a fraction
// of 2^24 and last on the final word. The 624 state words live in a ring of cells that shifts
// once per generated word, with the twist done incrementally at the tail, so once seeded a
// request of n words is accepted and then yields one word per cycle unless the output
// stalls. The first non-empty draw after reset or after a seed write first runs the seeding
// recurrence through the ring, one word per cycle, before its first word. A new draw is taken
// as soon as all words of the previous one are generated; the last of them may still wait in
// the output register.
`default_nettype none
module mersenne_twister_generator
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// seed register write
	input  wire logic              seed_we,
	input  wire logic [WORD_W-1:0] seed_value,
	// draw requests
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CNT_W-1:0]  how_many,
	// random words
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [WORD_W-1:0] random_word,
	output logic      [FRAC_W-1:0] unit_fraction,
	output logic                   last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic              seeded_q;
	logic [WORD_W-1:0] seed_q;
	logic [IDX_W-1:0]  seed_idx_q;
	logic [CNT_W-1:0]  remain_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;

	logic              in_take;
	logic [CNT_W-1:0]  req_words;
	logic              produce;
	logic [WORD_W-1:0] new_word;
	chain_ctrl_t       ctrl;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// oversized requests are clipped to the maximum
	assign req_words = (how_many > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : how_many;

	// a word is generated whenever the output register is free or being emptied
	assign produce = (state_q == ST_RUN) && (!out_valid_q || !out_stall);

	assign ctrl.shift     = produce || (state_q == ST_SEED);
	assign ctrl.seed_mode = (state_q == ST_SEED);
	assign ctrl.seed_idx  = seed_idx_q;

	mtg_chain u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.seed     (seed_q),
		.new_word (new_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			seed_q      <= SEED_RESET;
			seed_idx_q  <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			word_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			// the user must write the seed only while idle; the block itself does not enforce it
			if (seed_we) begin
				seed_q   <= seed_value;
				seeded_q <= 1'b0;
			end

			if (produce) begin
				out_valid_q <= 1'b1;
				word_q      <= temper_word(new_word);
				last_q      <= (remain_q == CNT_W'(1));
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					// an empty request changes nothing, not even the seeding
					if (in_take && (req_words != '0)) begin
						remain_q <= req_words;
						if (seeded_q) begin
							state_q <= ST_RUN;
						end else begin
							seed_idx_q <= '0;
							state_q    <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					if (seed_idx_q == IDX_W'(STATE_WORDS - 1)) begin
						seed_idx_q <= '0;
						seeded_q   <= 1'b1;
						state_q    <= ST_RUN;
					end else begin
						seed_idx_q <= seed_idx_q + IDX_W'(1);
					end
				end
				ST_RUN: begin
					if (produce) begin
						remain_q <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign random_word   = word_q;
	assign unit_fraction = word_q[FRAC_W-1:0];
	assign last          = last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mtg_checker.sv -----
// port-level checks on the mersenne twister generator, bound to the top level
`default_nettype none
module mtg_checker
	import mtg_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [CNT_W-1:0]  how_many,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [WORD_W-1:0] random_word,
	input wire logic [FRAC_W-1:0] unit_fraction,
	input wire logic              last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_word) && $stable(last))
		else $error("stalled result beat changed");

	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_fraction == random_word[FRAC_W-1:0])
		else $error("fraction does not match word");

	// an accepted non-empty draw is followed by in_stall being raised
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (how_many != '0) |=> in_stall)
		else $error("draw not held off after accept");

	// while a request still has words to come, no new draw is taken
	a_busy_mid_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> in_stall)
		else $error("draw taken in the middle of a request");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.how_many      (how_many),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.random_word   (random_word),
	.unit_fraction (unit_fraction),
	.last          (last)
);
`default_nettype wire
